// File: sv/mfm_pkg.sv
// ----------------------------------------------------------------------------
// Median-filtered minimum: shared package
// Common constants, the read-operation codes, and the command and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mfm_pkg;

  // Default capacity of the day store.
  localparam int MAX_DAYS_DEF = 64;

  // Width of one day number.
  localparam int DAY_W = 16;

  // Operation tag that travels with a store read and tells the datapath
  // what to do with the data when the registered read returns it on the next cycle.
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_CAND = 3'd1,
    OP_CNT  = 3'd2,
    OP_SUM  = 3'd3,
    OP_SCAN = 3'd4
  } rd_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   load;      // an input transaction is taken this cycle
    logic   clr_cnt;   // clear the below and same counters
    logic   take_med;  // candidate becomes the median
    logic   emit;      // write the result register and clear the set
    rd_op_t op;        // operation for the read issued this cycle
  } mfm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;         // candidate has the median rank
    logic out_busy;    // result register is full and stalled
  } mfm_stat_t;

endpackage

// File: sv/mfm_datapath.sv
// ----------------------------------------------------------------------------
// Median-filtered minimum: datapath
// Day store, set counters, rank counters, distance sum, scan and the
// result register.
// ----------------------------------------------------------------------------
module mfm_datapath #(
  parameter  int MAX_DAYS = mfm_pkg::MAX_DAYS_DEF,
  localparam int IDX_W    = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1,
  localparam int CNT_W    = $clog2(MAX_DAYS + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mfm_pkg::mfm_cmd_t       cmd,
  input  logic [IDX_W-1:0]        rd_addr,
  input  logic [mfm_pkg::DAY_W-1:0] in_day,
  input  logic                    in_has_day,
  input  logic                    out_stall,
  output mfm_pkg::mfm_stat_t      stat,
  output logic [CNT_W-1:0]        count,
  output logic                    out_valid,
  output logic [mfm_pkg::DAY_W-1:0] out_min_day,
  output logic                    out_found,
  output logic                    out_overflowed
);
  import mfm_pkg::*;

  localparam int TOT_W = DAY_W + CNT_W;

  logic [DAY_W-1:0] mem [MAX_DAYS];
  logic [DAY_W-1:0] rd_data_r;
  rd_op_t           rd_op_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] below_r, below_nxt;
  logic [CNT_W-1:0] same_r, same_nxt;
  logic [DAY_W-1:0] cand_r, cand_nxt;
  logic [DAY_W-1:0] med_r, med_nxt;
  logic [DAY_W-1:0] best_r, best_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [DAY_W-1:0] out_min_day_r, out_min_day_nxt;
  logic             out_found_r, out_found_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic             full;
  logic             wr_en;
  logic [DAY_W-1:0] gap;
  logic [TOT_W-1:0] prod;
  logic [CNT_W-1:0] rank_k;
  logic [CNT_W:0]   upper;

  assign full  = (count_r == CNT_W'(MAX_DAYS));
  assign wr_en = cmd.load && in_has_day && !full;

  // Store write at the fill position, registered read for the passes.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= in_day;
    end
    if (cmd.op != OP_NONE) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign gap    = (rd_data_r >= med_r) ? (rd_data_r - med_r) : (med_r - rd_data_r);
  assign prod   = TOT_W'(gap) * TOT_W'(count_r);
  assign rank_k = count_r >> 1;
  assign upper  = (CNT_W+1)'(below_r) + (CNT_W+1)'(same_r);

  assign stat.hit      = (below_r <= rank_k) && ((CNT_W+1)'(rank_k) < upper);
  assign stat.out_busy = out_valid_r && out_stall;

  always_comb begin
    count_nxt       = count_r;
    ovf_nxt         = ovf_r;
    below_nxt       = below_r;
    same_nxt        = same_r;
    cand_nxt        = cand_r;
    med_nxt         = med_r;
    best_nxt        = best_r;
    total_nxt       = total_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_min_day_nxt = out_min_day_r;
    out_found_nxt   = out_found_r;
    out_ovf_nxt     = out_ovf_r;

    if (cmd.load && in_has_day) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end

    if (cmd.clr_cnt) begin
      below_nxt = '0;
      same_nxt  = '0;
    end

    if (cmd.take_med) begin
      med_nxt   = cand_r;
      best_nxt  = cand_r;
      total_nxt = '0;
    end

    unique case (rd_op_r)
      OP_CAND: cand_nxt = rd_data_r;
      OP_CNT: begin
        if (rd_data_r < cand_r) begin
          below_nxt = below_r + CNT_W'(1);
        end else if (rd_data_r == cand_r) begin
          same_nxt = same_r + CNT_W'(1);
        end
      end
      OP_SUM:  total_nxt = total_r + TOT_W'(gap);
      OP_SCAN: begin
        if ((rd_data_r < best_r) && (prod <= total_r)) begin
          best_nxt = rd_data_r;
        end
      end
      default: ;
    endcase

    if (cmd.emit) begin
      out_valid_nxt   = 1'b1;
      out_found_nxt   = (count_r != '0);
      out_min_day_nxt = (count_r != '0) ? best_r : '0;
      out_ovf_nxt     = ovf_r;
      count_nxt       = '0;
      ovf_nxt         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      rd_op_r     <= OP_NONE;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      rd_op_r     <= cmd.op;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    below_r       <= below_nxt;
    same_r        <= same_nxt;
    cand_r        <= cand_nxt;
    med_r         <= med_nxt;
    best_r        <= best_nxt;
    total_r       <= total_nxt;
    out_min_day_r <= out_min_day_nxt;
    out_found_r   <= out_found_nxt;
    out_ovf_r     <= out_ovf_nxt;
  end

  assign count          = count_r;
  assign out_valid      = out_valid_r;
  assign out_min_day    = out_min_day_r;
  assign out_found      = out_found_r;
  assign out_overflowed = out_ovf_r;

endmodule

// File: sv/mfm_ctrl.sv
// ----------------------------------------------------------------------------
// Median-filtered minimum: controller
// Sequences loading, the rank selection passes, the distance sum, the scan
// and the hand-off of the result.
// ----------------------------------------------------------------------------
module mfm_ctrl #(
  parameter  int MAX_DAYS = mfm_pkg::MAX_DAYS_DEF,
  localparam int IDX_W    = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1,
  localparam int CNT_W    = $clog2(MAX_DAYS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_stall,
  input  mfm_pkg::mfm_stat_t stat,
  input  logic [CNT_W-1:0]   count,
  output mfm_pkg::mfm_cmd_t  cmd,
  output logic [IDX_W-1:0]   rd_addr
);
  import mfm_pkg::*;

  typedef enum logic [10:0] {
    S_LOAD     = 11'b000_0000_0001,
    S_START    = 11'b000_0000_0010,
    S_CAND     = 11'b000_0000_0100,
    S_CNT      = 11'b000_0000_1000,
    S_CNT_END  = 11'b000_0001_0000,
    S_CHECK    = 11'b000_0010_0000,
    S_SUM      = 11'b000_0100_0000,
    S_SUM_END  = 11'b000_1000_0000,
    S_SCAN     = 11'b001_0000_0000,
    S_SCAN_END = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic             j_last;

  assign j_last   = ((CNT_W'(j_r) + CNT_W'(1)) == count);
  assign in_stall = (state_r != S_LOAD);

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    cmd          = '0;
    cmd.op       = OP_NONE;
    rd_addr      = j_r;

    unique case (state_r)
      S_LOAD: begin
        cmd.load = in_valid;
        if (in_valid && in_last) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        i_nxt     = '0;
        state_nxt = (count == '0) ? S_DONE : S_CAND;
      end
      S_CAND: begin
        rd_addr     = i_r;
        cmd.op      = OP_CAND;
        cmd.clr_cnt = 1'b1;
        j_nxt       = '0;
        state_nxt   = S_CNT;
      end
      S_CNT: begin
        cmd.op = OP_CNT;
        if (j_last) begin
          state_nxt = S_CNT_END;
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      S_CNT_END: state_nxt = S_CHECK;
      S_CHECK: begin
        if (stat.hit) begin
          cmd.take_med = 1'b1;
          j_nxt        = '0;
          state_nxt    = S_SUM;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = S_CAND;
        end
      end
      S_SUM: begin
        cmd.op = OP_SUM;
        if (j_last) begin
          state_nxt = S_SUM_END;
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      S_SUM_END: begin
        j_nxt     = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (j_last) begin
          state_nxt = S_SCAN_END;
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      S_SCAN_END: state_nxt = S_DONE;
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
  end

endmodule

// File: sv/median_filtered_minimum.sv
// ----------------------------------------------------------------------------
// Median-filtered minimum: top level
// Collects a set of day numbers and returns the smallest day that is not an
// outlier with respect to the set's median.
// ----------------------------------------------------------------------------
// Days arrive one transaction per cycle and are written into an internal
// store of MAX_DAYS entries; a day that arrives when the store is full is
// dropped and the result reports overflowed. The transaction marked last
// closes the set (its own day is stored first, if it carries one). The block
// then raises in_stall while it works from the single-port store read: it
// finds the median (the element of sorted rank count/2) by testing
// candidates in store order, one full pass of count reads per candidate,
// then sums the absolute distances to the median in one pass, and in a
// final pass picks the smallest day whose distance times count does not
// exceed that sum. Before it emits, the block may also wait for a previous
// result still held in the output register. An empty set gives min_day 0
// with found low. Loading sustains one transaction per cycle, and a result
// that waits in the output register does not keep the next set from
// loading.
// ----------------------------------------------------------------------------
module median_filtered_minimum #(
  parameter int MAX_DAYS = mfm_pkg::MAX_DAYS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [mfm_pkg::DAY_W-1:0] in_day,
  input  logic                      in_has_day,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mfm_pkg::DAY_W-1:0] out_min_day,
  output logic                      out_found,
  output logic                      out_overflowed
);
  import mfm_pkg::*;

  localparam int IDX_W = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;
  localparam int CNT_W = $clog2(MAX_DAYS + 1);

  // Command and status between the sequencer and the datapath.
  mfm_cmd_t         cmd;
  mfm_stat_t        stat;
  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] count;

  mfm_ctrl #(
    .MAX_DAYS (MAX_DAYS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_stall (in_stall),
    .stat     (stat),
    .count    (count),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  mfm_datapath #(
    .MAX_DAYS (MAX_DAYS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .in_day         (in_day),
    .in_has_day     (in_has_day),
    .out_stall      (out_stall),
    .stat           (stat),
    .count          (count),
    .out_valid      (out_valid),
    .out_min_day    (out_min_day),
    .out_found      (out_found),
    .out_overflowed (out_overflowed)
  );

endmodule

// File: sv/mfm_checker.sv
// ----------------------------------------------------------------------------
// Median-filtered minimum: port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module mfm_port_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [mfm_pkg::DAY_W-1:0] in_day,
  input logic                      in_has_day,
  input logic                      in_last,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [mfm_pkg::DAY_W-1:0] out_min_day,
  input logic                      out_found,
  input logic                      out_overflowed
);

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_min_day) &&
      $stable(out_found) && $stable(out_overflowed))
    else $error("result changed while stalled");

  // An empty set always reports day zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_min_day == '0)
    else $error("not-found result carries a nonzero day");

  // Closing a set starts the computation, so input stalls next.
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> in_stall)
    else $error("input not stalled after the last transaction");

  // A new result is only produced at the end of a computation.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while loading");

endmodule

bind median_filtered_minimum mfm_port_checker u_mfm_checker (.*);

// File: tb/mfm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Median-filtered minimum: result checker
// Watches both channels of the block, keeps its own copy of the day set,
// predicts the result of every closed set, and compares each returned result
// against the oldest prediction.
// ----------------------------------------------------------------------------
module mfm_checker #(
  parameter int CAP = mfm_pkg::MAX_DAYS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [mfm_pkg::DAY_W-1:0] in_day,
  input  logic                      in_has_day,
  input  logic                      in_last,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [mfm_pkg::DAY_W-1:0] out_min_day,
  input  logic                      out_found,
  input  logic                      out_overflowed,
  output int                        pending,
  output int                        errors
);

  typedef struct packed {
    logic [mfm_pkg::DAY_W-1:0] min_day;
    logic                      found;
    logic                      overflowed;
  } set_result_t;

  logic [mfm_pkg::DAY_W-1:0] set_days [CAP];
  int unsigned               set_len;
  bit                        set_dropped;
  set_result_t               due_results [$];

  function automatic int unsigned day_gap(int unsigned a, int unsigned b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // The median is the day of sorted rank len/2; any day that sits no farther
  // from it than the mean distance may stand as the minimum.
  function automatic set_result_t filtered_min_of_set();
    set_result_t     r;
    int unsigned     rank;
    int unsigned     below;
    int unsigned     same;
    int unsigned     med;
    int unsigned     best;
    longint unsigned spread;
    bit              med_known;
    r.overflowed = set_dropped;
    if (set_len == 0) begin
      r.min_day = '0;
      r.found   = 1'b0;
      return r;
    end
    rank      = set_len / 2;
    med       = 0;
    med_known = 1'b0;
    for (int i = 0; i < set_len; i++) begin
      if (!med_known) begin
        below = 0;
        same  = 0;
        for (int j = 0; j < set_len; j++) begin
          if (set_days[j] < set_days[i]) below++;
          else if (set_days[j] == set_days[i]) same++;
        end
        if (below <= rank && rank < below + same) begin
          med       = set_days[i];
          med_known = 1'b1;
        end
      end
    end
    spread = 0;
    for (int i = 0; i < set_len; i++) spread += day_gap(set_days[i], med);
    best = med;
    for (int i = 0; i < set_len; i++) begin
      if (set_days[i] < best &&
          longint'(day_gap(set_days[i], med)) * set_len <= spread) begin
        best = set_days[i];
      end
    end
    r.min_day = best[mfm_pkg::DAY_W-1:0];
    r.found   = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    set_result_t want;
    if (!rst_n) begin
      set_len     = 0;
      set_dropped = 1'b0;
      pending     = 0;
      errors      = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (in_has_day) begin
          if (set_len < CAP) begin
            set_days[set_len] = in_day;
            set_len++;
          end else begin
            set_dropped = 1'b1;
          end
        end
        if (in_last) begin
          due_results.insert(due_results.size(), filtered_min_of_set());
          set_len     = 0;
          set_dropped = 1'b0;
        end
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got min_day %0d found %0b ovf %0b",
                   $time, out_min_day, out_found, out_overflowed);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (out_min_day !== want.min_day) begin
            $display("%0t: min_day expected %0d, got %0d", $time, want.min_day, out_min_day);
            errors++;
          end
          if (out_found !== want.found) begin
            $display("%0t: found expected %0b, got %0b", $time, want.found, out_found);
            errors++;
          end
          if (out_overflowed !== want.overflowed) begin
            $display("%0t: overflowed expected %0b, got %0b",
                     $time, want.overflowed, out_overflowed);
            errors++;
          end
        end
      end
      pending = due_results.size();
    end
  end

endmodule

// File: tb/tb_median_filtered_minimum.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Median-filtered minimum: testbench top
// Drives day sets into the block, stalls the result side at random, and
// reports the verdict from the failure count of the checker beside the block.
// ----------------------------------------------------------------------------
module tb_median_filtered_minimum;

  localparam int          DAY_W       = mfm_pkg::DAY_W;
  localparam int          CAP         = mfm_pkg::MAX_DAYS_DEF;
  // Number of counted day and end-marker transactions to offer in total.
  localparam int          ITEM_TARGET = 1000;
  // Watchdog limit in cycles, set far beyond what the whole run needs, so
  // this leaves a wide margin.
  localparam int unsigned LIMIT       = 1_000_000;
  // Length of the single long hold on the result side.
  localparam int          HOLD_CYCLES = 600;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [DAY_W-1:0] in_day;
  logic             in_has_day;
  logic             in_last;
  logic             out_valid;
  logic             out_stall;
  logic [DAY_W-1:0] out_min_day;
  logic             out_found;
  logic             out_overflowed;

  int               pending;
  int               errors;
  int unsigned      cycle_cnt = 0;
  int               items_sent;
  // While calm is high neither side inserts idle cycles or stalls.
  logic             calm;
  // Raised once by the sender to ask the receiver for its long hold.
  logic             squeeze;

  median_filtered_minimum DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_day         (in_day),
    .in_has_day     (in_has_day),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_min_day    (out_min_day),
    .out_found      (out_found),
    .out_overflowed (out_overflowed)
  );

  mfm_checker #(.CAP(CAP)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_day         (in_day),
    .in_has_day     (in_has_day),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_min_day    (out_min_day),
    .out_found      (out_found),
    .out_overflowed (out_overflowed),
    .pending        (pending),
    .errors         (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Free-running cycle count; the watchdog below ends a run that hangs.
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= LIMIT);
    $display("median_filtered_minimum: mismatch");
    $finish;
  end

  // Result side. Outside the calm stretch the receiver stalls on about 27
  // percent of cycles. When the sender raises squeeze, the receiver holds
  // off for a long stretch so that one result sits in the output register,
  // the next set finishes its work behind it, and the block has to stall its
  // input while the sender keeps offering transactions.
  initial begin
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (squeeze && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 27);
      end
    end
  end

  // Offers one transaction, starting at a falling edge, and returns at the
  // falling edge after the one at which it was accepted. Idle cycles before
  // it carry random junk on the payload. Only transactions that the block
  // acts on (a day or an end marker) count toward the target.
  task automatic send_item(logic [DAY_W-1:0] day, logic has_day, logic last);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid   <= 1'b0;
      in_day     <= DAY_W'($urandom);
      in_has_day <= 1'($urandom);
      in_last    <= 1'($urandom);
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_day     <= day;
    in_has_day <= has_day;
    in_last    <= last;
    do @(posedge clk); while (in_stall);
    if (has_day || last) items_sent++;
    @(negedge clk);
  endtask

  // Drops valid and waits until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Picks one day in the given style: uniform over the whole range, a tight
  // cluster around a base with an occasional outlier, or the range ends.
  function automatic logic [DAY_W-1:0] pick_day(int style, int base);
    int v;
    case (style)
      1: begin
        if ($urandom_range(99) < 12) v = $urandom_range(65535);
        else v = base + $urandom_range(400) - 200;
      end
      2: begin
        case ($urandom_range(3))
          0: v = 0;
          1: v = 65535;
          2: v = $urandom_range(3);
          default: v = 65535 - $urandom_range(3);
        endcase
      end
      default: v = $urandom_range(65535);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return DAY_W'(v);
  endfunction

  // Sends a set of n days. The set closes either on its own last day or on a
  // bare end marker; an empty set is a lone end marker. Now and then a
  // transaction without a day and without last is slipped in: the block must
  // ignore it, whatever its day field holds.
  task automatic send_set(int n, bit bare_end, int style);
    int base;
    base = $urandom_range(65535);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) send_item(DAY_W'($urandom), 1'b0, 1'b0);
      send_item(pick_day(style, base), 1'b1, (i == n - 1) && !bare_end);
    end
    if (n == 0 || bare_end) send_item(DAY_W'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int n;
    int r;
    int small_left;
    in_valid   = 1'b0;
    in_day     = '0;
    in_has_day = 1'b0;
    in_last    = 1'b0;
    calm       = 1'b0;
    squeeze    = 1'b0;
    items_sent = 0;
    small_left = 0;
    rst_n      = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed sets. An empty set gives found low.
    send_item(16'h0000, 1'b0, 1'b1);
    // Single days at both ends of the range.
    send_item(16'h0000, 1'b1, 1'b1);
    send_item(16'hFFFF, 1'b1, 1'b1);
    // A transaction without a day is ignored even with a nonzero day field.
    send_item(16'hABCD, 1'b0, 1'b0);
    send_item(16'h0005, 1'b1, 1'b1);
    // A far outlier, closed by a bare end marker.
    send_item(16'd100, 1'b1, 1'b0);
    send_item(16'd200, 1'b1, 1'b0);
    send_item(16'd50000, 1'b1, 1'b0);
    send_item(16'hFFFF, 1'b0, 1'b1);
    // Range ends together, with repeated values.
    send_item(16'h0000, 1'b1, 1'b0);
    send_item(16'hFFFF, 1'b1, 1'b0);
    send_item(16'hFFFF, 1'b1, 1'b0);
    send_item(16'hFFFF, 1'b1, 1'b1);
    // All days equal.
    send_item(16'd7, 1'b1, 1'b0);
    send_item(16'd7, 1'b1, 1'b0);
    send_item(16'd7, 1'b1, 1'b1);
    // Low outlier below a tight group: it must be rejected.
    send_item(16'd10, 1'b1, 1'b0);
    send_item(16'd1000, 1'b1, 1'b0);
    send_item(16'd1001, 1'b1, 1'b0);
    send_item(16'd1002, 1'b1, 1'b1);

    // Pause the sender until every directed result is back.
    drain_results();

    // A set that fills the store exactly, then one that runs past capacity:
    // the days after the 64th are dropped and the result flags it.
    send_set(CAP, 1'b0, 1);
    send_set(CAP + 6, 1'b1, 1);

    while (items_sent < ITEM_TARGET) begin
      calm <= (items_sent >= 400 && items_sent < 560);
      if (!squeeze && items_sent >= 250) begin
        squeeze    <= 1'b1;
        small_left = 10;
      end
      r = $urandom_range(99);
      if (small_left > 0) begin
        n = $urandom_range(3, 1);
        small_left--;
      end else if (r < 3) n = 0;
      else if (r < 88) n = $urandom_range(12, 1);
      else if (r < 97) n = $urandom_range(40, 13);
      else n = $urandom_range(CAP + 8, CAP - 4);
      send_set(n, $urandom_range(99) < 25, $urandom_range(2));
    end
    in_valid <= 1'b0;

    // All sets are in; let the last results drain, then give the block a
    // little longer so that a stray extra result would still be seen.
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("median_filtered_minimum: match");
    end else begin
      $display("median_filtered_minimum: mismatch");
    end
    $finish;
  end

endmodule
